// ----- design/bf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bilateral filter package
// Shared constants, payload types and helper functions for the RGB
// bilateral filter front end, job queue and compute back end.
// ----------------------------------------------------------------------------
package bf_pkg;

  // Window and store geometry.
  localparam int MAX_RADIUS      = 3;
  localparam int TAPS_SIDE       = 2 * MAX_RADIUS + 1;
  localparam int SPATIAL_ENTRIES = TAPS_SIDE * TAPS_SIDE;
  localparam int SPATIAL_AW      = 6;
  localparam int RANGE_ENTRIES   = 256;
  localparam int MAX_WIDTH       = 1024;
  localparam int MAX_HEIGHT      = 4096;
  localparam int COL_BITS        = 10;
  localparam int ROW_BITS        = 12;
  localparam int SLOT_BITS       = 3;
  localparam int STORE_AW        = SLOT_BITS + COL_BITS;
  localparam int STORE_DEPTH     = TAPS_SIDE * MAX_WIDTH;
  localparam int WEIGHT_BITS     = 16;
  localparam int GAP_BITS        = 23;
  localparam int DEN_BITS        = 22;
  localparam int NUM_BITS        = 30;
  localparam int REM_BITS        = 31;
  localparam int JOBQ_DEPTH      = 4;
  localparam int JOBQ_AW         = 2;

  // Item operations.
  localparam logic [1:0] OP_PIXEL   = 2'd0;
  localparam logic [1:0] OP_DRAIN   = 2'd1;
  localparam logic [1:0] OP_LOAD_SP = 2'd2;
  localparam logic [1:0] OP_LOAD_RG = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;
  localparam logic [1:0] CFG_MODE   = 2'd3;

  // Border modes; any other code drops outside taps.
  localparam logic [1:0] MODE_ZERO   = 2'd0;
  localparam logic [1:0] MODE_MIRROR = 2'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  table_index;
    logic [15:0] weight_value;
  } in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } out_t;

  // Effective frame geometry handed from front to back.
  typedef struct packed {
    logic [10:0] w;
    logic [12:0] h;
    logic [1:0]  r;
    logic [1:0]  mode;
  } geom_t;

  // One unit of work for the back end.
  typedef struct packed {
    logic                 ld_sp;
    logic                 ld_rg;
    logic                 wr;
    logic                 emit;
    logic [23:0]          pix;
    logic [SLOT_BITS-1:0] wslot;
    logic [COL_BITS-1:0]  wcol;
    logic [7:0]           idx;
    logic [15:0]          weight;
    logic [ROW_BITS-1:0]  orow;
    logic [COL_BITS-1:0]  ocol;
    logic [SLOT_BITS-1:0] oslot;
    logic                 last;
  } job_t;

  // Mirror a coordinate c+d back into [0, n-1].
  function automatic logic signed [13:0] reflect_coord(input logic signed [13:0] c,
                                                       input logic signed [13:0] d,
                                                       input logic signed [13:0] n);
    logic signed [13:0] p;
    p = c + d;
    if (p > n - 14'sd1) p = c - d;
    else if (p < 14'sd0) p = -p;
    if (p < 14'sd0) p = 14'sd0;
    if (p > n - 14'sd1) p = n - 14'sd1;
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- design/bf_jobq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bilateral filter job queue
// Short first-in first-out queue of jobs between the front end and the
// compute back end.
// ----------------------------------------------------------------------------
module bf_jobq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bf_pkg::job_t  push_data,
  output logic               full,
  input  wire logic          pop,
  output bf_pkg::job_t       head,
  output logic               empty
);

  bf_pkg::job_t                entry_r [bf_pkg::JOBQ_DEPTH];
  logic [bf_pkg::JOBQ_AW-1:0]  wp_r;
  logic [bf_pkg::JOBQ_AW-1:0]  rp_r;
  logic [bf_pkg::JOBQ_AW:0]    cnt_r;

  assign full  = (cnt_r == (bf_pkg::JOBQ_AW+1)'(bf_pkg::JOBQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = entry_r[rp_r];

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) entry_r[wp_r] <= push_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (bf_pkg::JOBQ_AW+1)'(push) - (bf_pkg::JOBQ_AW+1)'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (bf_pkg::JOBQ_AW+1)'(bf_pkg::JOBQ_DEPTH))
    else $error("job queue count overflow");
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("job pushed into a full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job popped from an empty queue");

endmodule
`default_nettype wire

// ----- design/bf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bilateral filter front end
// Holds the configuration registers and the raster positions, accepts items
// and turns each into at most one job for the back end.
// ----------------------------------------------------------------------------
module bf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire bf_pkg::in_t   in_data,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [12:0]   cfg_data,
  output logic               job_push,
  output bf_pkg::job_t       job_data,
  input  wire logic          q_full,
  output bf_pkg::geom_t      geom
);

  logic [10:0] width_r, width_nxt;
  logic [12:0] height_r, height_nxt;
  logic [1:0]  radius_r, radius_nxt;
  logic [1:0]  mode_r, mode_nxt;

  logic [bf_pkg::ROW_BITS-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [bf_pkg::COL_BITS-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [bf_pkg::SLOT_BITS-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic                         done_r, done_nxt;
  logic [bf_pkg::GAP_BITS-1:0]  gap_r, gap_nxt;

  logic [10:0] eff_w;
  logic [12:0] eff_h;
  logic [1:0]  eff_r;
  logic [12:0] lag;
  logic        accept, wr, emit, last;

  // Effective geometry from the raw registers.
  always_comb begin
    eff_w = (width_r == '0) ? 11'd1 :
            (width_r > 11'(bf_pkg::MAX_WIDTH)) ? 11'(bf_pkg::MAX_WIDTH) : width_r;
    eff_h = (height_r == '0) ? 13'd1 :
            (height_r > 13'(bf_pkg::MAX_HEIGHT)) ? 13'(bf_pkg::MAX_HEIGHT) : height_r;
    eff_r = (radius_r == '0) ? 2'd1 : radius_r;
    lag   = 13'(eff_w) + 13'(eff_r) + ((eff_r >= 2'd2) ? 13'(eff_w) : 13'd0) +
            ((eff_r == 2'd3) ? 13'(eff_w) : 13'd0);
  end

  assign geom.w    = eff_w;
  assign geom.h    = eff_h;
  assign geom.r    = eff_r;
  assign geom.mode = mode_r;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign last    = (out_row_r == 12'(eff_h - 13'd1)) && (out_col_r == 10'(eff_w - 11'd1));

  // Item classification and position tracking.
  always_comb begin
    width_nxt    = width_r;
    height_nxt   = height_r;
    radius_nxt   = radius_r;
    mode_nxt     = mode_r;
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    in_slot_nxt  = in_slot_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_slot_nxt = out_slot_r;
    done_nxt     = done_r;
    job_data     = '0;
    wr           = 1'b0;
    emit         = 1'b0;

    if (accept) begin
      case (in_data.operation)
        bf_pkg::OP_LOAD_SP: begin
          job_data.ld_sp = (in_data.table_index < 8'(bf_pkg::SPATIAL_ENTRIES));
        end
        bf_pkg::OP_LOAD_RG: begin
          job_data.ld_rg = 1'b1;
        end
        default: begin
          if (done_r) begin
            emit = 1'b1;
          end else if (in_data.operation == bf_pkg::OP_PIXEL) begin
            wr = 1'b1;
            if ({1'b0, in_col_r} + 11'd1 >= eff_w) begin
              in_col_nxt  = '0;
              in_slot_nxt = (in_slot_r == 3'(bf_pkg::TAPS_SIDE - 1)) ? '0 : in_slot_r + 3'd1;
              in_row_nxt  = in_row_r + 12'd1;
              if ({1'b0, in_row_r} + 13'd1 >= eff_h) begin
                in_row_nxt  = '0;
                in_slot_nxt = '0;
                done_nxt    = 1'b1;
              end
            end else begin
              in_col_nxt = in_col_r + 10'd1;
            end
            emit = done_nxt || (gap_r + 23'd1 > 23'(lag));
          end
        end
      endcase
    end

    job_data.weight = in_data.weight_value;
    job_data.idx    = in_data.table_index;
    job_data.wr     = wr;
    job_data.pix    = {in_data.blue_in, in_data.green_in, in_data.red_in};
    job_data.wslot  = in_slot_r;
    job_data.wcol   = in_col_r;
    job_data.emit   = emit;
    job_data.orow   = out_row_r;
    job_data.ocol   = out_col_r;
    job_data.oslot  = out_slot_r;
    job_data.last   = last;
    job_push = job_data.ld_sp || job_data.ld_rg || wr || emit;

    gap_nxt = gap_r + 23'(wr) - 23'(emit);

    // Output position advance; the last pixel restarts the frame.
    if (emit) begin
      if (last) begin
        in_row_nxt   = '0;
        in_col_nxt   = '0;
        in_slot_nxt  = '0;
        out_row_nxt  = '0;
        out_col_nxt  = '0;
        out_slot_nxt = '0;
        done_nxt     = 1'b0;
        gap_nxt      = '0;
      end else if ({1'b0, out_col_r} + 11'd1 >= eff_w) begin
        out_col_nxt  = '0;
        out_row_nxt  = out_row_r + 12'd1;
        out_slot_nxt = (out_slot_r == 3'(bf_pkg::TAPS_SIDE - 1)) ? '0 : out_slot_r + 3'd1;
      end else begin
        out_col_nxt = out_col_r + 10'd1;
      end
    end

    // Register writes; geometry changes abandon the frame.
    if (cfg_we) begin
      case (cfg_index)
        bf_pkg::CFG_WIDTH:  width_nxt  = cfg_data[10:0];
        bf_pkg::CFG_HEIGHT: height_nxt = cfg_data;
        bf_pkg::CFG_RADIUS: radius_nxt = cfg_data[1:0];
        default:            mode_nxt   = cfg_data[1:0];
      endcase
      if (cfg_index != bf_pkg::CFG_MODE) begin
        in_row_nxt   = '0;
        in_col_nxt   = '0;
        in_slot_nxt  = '0;
        out_row_nxt  = '0;
        out_col_nxt  = '0;
        out_slot_nxt = '0;
        done_nxt     = 1'b0;
        gap_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 11'd640;
      height_r   <= 13'd480;
      radius_r   <= 2'd3;
      mode_r     <= 2'd2;
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_slot_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_slot_r <= '0;
      done_r     <= 1'b0;
      gap_r      <= '0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      radius_r   <= radius_nxt;
      mode_r     <= mode_nxt;
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      in_slot_r  <= in_slot_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_slot_r <= out_slot_nxt;
      done_r     <= done_nxt;
      gap_r      <= gap_nxt;
    end
  end

  a_done_parks_input: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (in_row_r == '0) && (in_col_r == '0) && (in_slot_r == '0))
    else $error("input position not parked after frame input");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_slot_r < 3'(bf_pkg::TAPS_SIDE)) && (out_slot_r < 3'(bf_pkg::TAPS_SIDE)))
    else $error("line slot out of range");
  a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !done_r |-> gap_r <= 23'(lag))
    else $error("output lag exceeded");

endmodule
`default_nettype wire

// ----- design/bf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bilateral filter back end
// Owns the line store and weight tables, runs the window through a tap
// pipeline, divides per channel and buffers the results.
// ----------------------------------------------------------------------------
module bf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_empty,
  input  wire bf_pkg::job_t   job_data,
  output logic                job_pop,
  input  wire bf_pkg::geom_t  geom,
  output logic                out_empty,
  input  wire logic           out_pop,
  output bf_pkg::out_t        out_data
);

  typedef enum logic [2:0] {S_IDLE, S_CTR, S_CWAIT, S_TAP, S_FLUSH, S_DIV, S_OUT} state_t;

  state_t state_r;

  // Latched emit job.
  logic [bf_pkg::ROW_BITS-1:0]  orow_r;
  logic [bf_pkg::COL_BITS-1:0]  ocol_r;
  logic [bf_pkg::SLOT_BITS-1:0] oslot_r;
  logic                         last_r;
  logic [23:0]                  center_r;
  logic [2:0]                   ty_r, tx_r;
  logic [2:0]                   tap_lo, tap_hi;

  // Memories and their read data.
  logic [23:0] store_mem [bf_pkg::STORE_DEPTH];
  logic [15:0] sp_mem [bf_pkg::SPATIAL_ENTRIES];
  logic [23:0] ls_q;
  logic [15:0] sp_q;
  logic [15:0] rg_q [3];
  logic [bf_pkg::STORE_AW-1:0]   ls_raddr, tap_addr;
  logic [bf_pkg::SPATIAL_AW-1:0] sp_raddr;
  logic [7:0]                    diff [3];

  // Pipeline registers.
  logic        a_v_r, a_zero_r;
  logic        b_v_r;
  logic [23:0] b_pix_r;
  logic [15:0] b_sw_r;
  logic        c_v_r;
  logic [23:0] c_pix_r;
  logic [15:0] c_wt_r [3];

  logic [bf_pkg::DEN_BITS-1:0] den_r [3];
  logic [bf_pkg::NUM_BITS-1:0] num_r [3];
  logic [bf_pkg::REM_BITS-1:0] rem_r [3];
  logic [7:0]                  quo_r [3];
  logic [2:0]                  bit_r;

  // Result buffer.
  bf_pkg::out_t ofifo_r [2];
  logic         owp_r, orp_r;
  logic [1:0]   ocnt_r;
  logic         opush;
  bf_pkg::out_t ores;

  // Tap address generation.
  logic signed [3:0]  dy, dx;
  logic signed [13:0] dy14, dx14, orow_s, ocol_s, h_s, w_s, rr, cc, rsel, csel, rdiff;
  logic signed [4:0]  slot_s;
  logic               in_frame, keep, zero;
  logic [2:0]         rslot;
  logic [bf_pkg::SPATIAL_AW-1:0] ty6, tx6;

  assign tap_lo = 3'd3 - {1'b0, geom.r};
  assign tap_hi = 3'd3 + {1'b0, geom.r};

  always_comb begin
    dy     = $signed({1'b0, ty_r}) - 4'sd3;
    dx     = $signed({1'b0, tx_r}) - 4'sd3;
    dy14   = {{10{dy[3]}}, dy};
    dx14   = {{10{dx[3]}}, dx};
    orow_s = $signed({2'b00, orow_r});
    ocol_s = $signed({4'b0000, ocol_r});
    h_s    = $signed({1'b0, geom.h});
    w_s    = $signed({3'b000, geom.w});
    rr     = orow_s + dy14;
    cc     = ocol_s + dx14;
    in_frame = !rr[13] && (rr < h_s) && !cc[13] && (cc < w_s);
    rsel   = orow_s;
    csel   = ocol_s;
    keep   = 1'b1;
    zero   = 1'b0;
    if (in_frame) begin
      rsel = rr;
      csel = cc;
    end else begin
      case (geom.mode)
        bf_pkg::MODE_ZERO: zero = 1'b1;
        bf_pkg::MODE_MIRROR: begin
          rsel = bf_pkg::reflect_coord(orow_s, dy14, h_s);
          csel = bf_pkg::reflect_coord(ocol_s, dx14, w_s);
        end
        default: keep = 1'b0;
      endcase
    end
    // Ring slot of the selected row, relative to the center row slot.
    rdiff  = rsel - orow_s;
    slot_s = $signed({2'b00, oslot_r}) + rdiff[4:0];
    if (slot_s < 5'sd0) slot_s = slot_s + 5'sd7;
    else if (slot_s >= 5'sd7) slot_s = slot_s - 5'sd7;
    rslot    = slot_s[2:0];
    tap_addr = {rslot, csel[9:0]};
    ls_raddr = (state_r == S_CTR) ? {oslot_r, ocol_r} : tap_addr;
    ty6      = {3'b000, ty_r};
    tx6      = {3'b000, tx_r};
    sp_raddr = (ty6 << 3) - ty6 + tx6;
  end

  assign job_pop = (state_r == S_IDLE) && !job_empty;

  // Line store and spatial table.
  always_ff @(posedge clk) begin
    if (job_pop && job_data.wr) store_mem[{job_data.wslot, job_data.wcol}] <= job_data.pix;
    ls_q <= store_mem[ls_raddr];
  end

  always_ff @(posedge clk) begin
    if (job_pop && job_data.ld_sp) sp_mem[job_data.idx[bf_pkg::SPATIAL_AW-1:0]] <=
      job_data.weight[bf_pkg::WEIGHT_BITS-1:0];
    sp_q <= sp_mem[sp_raddr];
  end

  // One range table copy per channel lane, each read at its own difference.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [15:0] rg_mem [bf_pkg::RANGE_ENTRIES];
    logic [7:0]  cv, pv;
    assign cv      = center_r[8*k +: 8];
    assign pv      = a_zero_r ? 8'd0 : ls_q[8*k +: 8];
    assign diff[k] = (cv > pv) ? cv - pv : pv - cv;
    always_ff @(posedge clk) begin
      if (job_pop && job_data.ld_rg) rg_mem[job_data.idx] <= job_data.weight;
      rg_q[k] <= rg_mem[diff[k]];
    end
  end

  // Division step per lane.
  logic [bf_pkg::REM_BITS-1:0] dsh [3];
  logic                        ge [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsh[k] = bf_pkg::REM_BITS'(den_r[k]) << bit_r;
      ge[k]  = rem_r[k] >= dsh[k];
    end
  end

  // Result assembly; a zero denominator passes the center sample.
  always_comb begin
    ores.red_out   = (den_r[0] == '0) ? center_r[7:0]   : quo_r[0];
    ores.green_out = (den_r[1] == '0) ? center_r[15:8]  : quo_r[1];
    ores.blue_out  = (den_r[2] == '0) ? center_r[23:16] : quo_r[2];
    ores.frame_end = last_r;
  end

  assign opush     = (state_r == S_OUT) && (ocnt_r != 2'd2);
  assign out_empty = (ocnt_r == 2'd0);
  assign out_data  = ofifo_r[orp_r];

  // Tap pipeline payload.
  always_ff @(posedge clk) begin
    b_pix_r <= a_zero_r ? 24'd0 : ls_q;
    b_sw_r  <= sp_q;
    c_pix_r <= b_pix_r;
    for (int k = 0; k < 3; k++) begin
      c_wt_r[k] <= 16'((32'(b_sw_r) * 32'(rg_q[k])) >> bf_pkg::WEIGHT_BITS);
    end
    if (state_r == S_CWAIT) center_r <= ls_q;
    if (opush) ofifo_r[owp_r] <= ores;
  end

  // Sequencer, accumulators and divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      a_v_r    <= 1'b0;
      a_zero_r <= 1'b0;
      b_v_r    <= 1'b0;
      c_v_r    <= 1'b0;
      owp_r    <= 1'b0;
      orp_r    <= 1'b0;
      ocnt_r   <= '0;
      ty_r     <= '0;
      tx_r     <= '0;
      bit_r    <= '0;
    end else begin
      a_v_r    <= (state_r == S_TAP) && keep;
      a_zero_r <= zero;
      b_v_r    <= a_v_r;
      c_v_r    <= b_v_r;
      if (c_v_r) begin
        for (int k = 0; k < 3; k++) begin
          den_r[k] <= den_r[k] + bf_pkg::DEN_BITS'(c_wt_r[k]);
          num_r[k] <= num_r[k] +
                      bf_pkg::NUM_BITS'(24'(c_wt_r[k]) * 24'(c_pix_r[8*k +: 8]));
        end
      end
      case (state_r)
        S_IDLE: begin
          if (job_pop && job_data.emit) begin
            orow_r  <= job_data.orow;
            ocol_r  <= job_data.ocol;
            oslot_r <= job_data.oslot;
            last_r  <= job_data.last;
            state_r <= S_CTR;
          end
        end
        S_CTR: state_r <= S_CWAIT;
        S_CWAIT: begin
          ty_r <= tap_lo;
          tx_r <= tap_lo;
          for (int k = 0; k < 3; k++) begin
            den_r[k] <= '0;
            num_r[k] <= '0;
          end
          state_r <= S_TAP;
        end
        S_TAP: begin
          if (tx_r == tap_hi) begin
            tx_r <= tap_lo;
            ty_r <= ty_r + 3'd1;
            if (ty_r == tap_hi) state_r <= S_FLUSH;
          end else begin
            tx_r <= tx_r + 3'd1;
          end
        end
        S_FLUSH: begin
          if (!a_v_r && !b_v_r && !c_v_r) begin
            for (int k = 0; k < 3; k++) begin
              rem_r[k] <= bf_pkg::REM_BITS'(num_r[k]) + bf_pkg::REM_BITS'(den_r[k] >> 1);
            end
            bit_r   <= 3'd7;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          for (int k = 0; k < 3; k++) begin
            if (ge[k]) rem_r[k] <= rem_r[k] - dsh[k];
            quo_r[k] <= {quo_r[k][6:0], ge[k]};
          end
          bit_r <= bit_r - 3'd1;
          if (bit_r == 3'd0) state_r <= S_OUT;
        end
        S_OUT: begin
          if (opush) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (opush) owp_r <= ~owp_r;
      if (out_pop && !out_empty) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + 2'(opush) - 2'(out_pop && !out_empty);
    end
  end

  a_tap_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r |-> $past(state_r) == S_TAP)
    else $error("tap issued outside the window scan");
  a_div_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !(a_v_r || b_v_r || c_v_r))
    else $error("division started with taps in flight");
  a_obuf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 2'd2)
    else $error("result buffer overflow");

endmodule
`default_nettype wire

// ----- design/bilateral_filter_rgb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RGB bilateral filter top level
// Streams raster-order RGB pixels through a per-channel bilateral filter
// with loadable spatial and range weight tables.
// ----------------------------------------------------------------------------
// Pixel, drain and table-load items enter through a queue-style push port;
// filtered pixels leave in raster order through a queue-style pop port,
// trailing the input by R*W+R pixels, and drain items flush the tail of a
// frame. Each output pixel is computed by the back end, one window tap per
// cycle through a tap pipeline, followed by a restoring division that runs
// in parallel for each of the three channels. A four-entry job queue lets
// the front end keep accepting items while the back end works, and a
// two-entry result buffer lets the back end finish while the consumer
// stalls. Weight tables and the line store come up undefined and must be
// loaded before use.
module bilateral_filter_rgb_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire bf_pkg::in_t   in_data,
  output logic               out_empty,
  input  wire logic          out_pop,
  output bf_pkg::out_t       out_data,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [12:0]   cfg_data
);

  logic          job_push, job_full, job_pop, job_empty;
  bf_pkg::job_t  job_in, job_head;
  bf_pkg::geom_t geom;

  bf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_push  (job_push),
    .job_data  (job_in),
    .q_full    (job_full),
    .geom      (geom)
  );

  bf_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .head      (job_head),
    .empty     (job_empty)
  );

  bf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_data  (job_head),
    .job_pop   (job_pop),
    .geom      (geom),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- sim/bilateral_filter_rgb_top_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RGB bilateral filter testbench
// Drives pixel, drain and weight-load items into the filter and checks every
// filtered pixel against an in-bench bilateral filter predictor, across border
// modes, geometry extremes, random frames and input and output back-pressure.
// ----------------------------------------------------------------------------
module bilateral_filter_rgb_top_tb;

  logic          clk;
  logic          rst_n;
  logic          in_push;
  logic          in_full;
  bf_pkg::in_t   in_data;
  logic          out_empty;
  logic          out_pop;
  bf_pkg::out_t  out_data;
  logic          cfg_we;
  logic  [1:0]   cfg_index;
  logic  [12:0]  cfg_data;

  // Expected filtered pixels, oldest first.
  bf_pkg::out_t  pixel_q[$];
  int    mismatches;
  int    send_idle_pct;
  int    pop_stall_pct;
  int    hold_req;
  int    hold_left;
  int    items_sent;

  // Predictor state.
  logic [23:0] line_mem [0:bf_pkg::STORE_DEPTH-1];
  logic [15:0] sp_weight [0:bf_pkg::SPATIAL_ENTRIES-1];
  logic [15:0] rg_weight [0:bf_pkg::RANGE_ENTRIES-1];
  int unsigned reg_w, reg_h, reg_r, reg_mode;
  int unsigned in_row, in_col, out_row, out_col;
  bit          frame_in_done;

  bilateral_filter_rgb_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock.
  always #6 clk = ~clk;

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned geo_w();
    return (reg_w < 1) ? 1 : (reg_w > bf_pkg::MAX_WIDTH) ? bf_pkg::MAX_WIDTH : reg_w;
  endfunction

  function automatic int unsigned geo_h();
    return (reg_h < 1) ? 1 : (reg_h > bf_pkg::MAX_HEIGHT) ? bf_pkg::MAX_HEIGHT : reg_h;
  endfunction

  function automatic int unsigned geo_r();
    return (reg_r < 1) ? 1 : (reg_r > bf_pkg::MAX_RADIUS) ? bf_pkg::MAX_RADIUS : reg_r;
  endfunction

  function automatic int unsigned line_addr(int unsigned row, int unsigned col);
    return (row % bf_pkg::TAPS_SIDE) * bf_pkg::MAX_WIDTH + (col % bf_pkg::MAX_WIDTH);
  endfunction

  // Reflect c+d back into the frame, then clamp.
  function automatic int mirror_pos(int c, int d, int n);
    int p;
    p = c + d;
    if (p > n - 1) p = c - d;
    else if (p < 0) p = -p;
    if (p < 0) p = 0;
    if (p > n - 1) p = n - 1;
    return p;
  endfunction

  function automatic void restart_frame();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
    frame_in_done = 0;
  endfunction

  // Filter the pixel at the output position and advance that position.
  function automatic bf_pkg::out_t filter_pixel();
    int w, h, r, orow, ocol, rr, cc, dy, dx, k, cv, pv, diff;
    logic [23:0] ctr, px;
    longint unsigned num [3];
    longint unsigned den [3];
    longint unsigned sw, wt, v;
    bit used, last;
    bf_pkg::out_t res;
    w = geo_w();
    h = geo_h();
    r = geo_r();
    orow = out_row;
    ocol = out_col;
    ctr = line_mem[line_addr(out_row, out_col)];
    for (k = 0; k < 3; k++) begin
      num[k] = 0;
      den[k] = 0;
    end
    for (dy = -r; dy <= r; dy++) begin
      for (dx = -r; dx <= r; dx++) begin
        rr = orow + dy;
        cc = ocol + dx;
        used = 1;
        px = '0;
        sw = sp_weight[(dy + bf_pkg::MAX_RADIUS) * bf_pkg::TAPS_SIDE + dx +
                       bf_pkg::MAX_RADIUS];
        if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
          px = line_mem[line_addr(rr, cc)];
        end else if (reg_mode == bf_pkg::MODE_ZERO) begin
          px = '0;
        end else if (reg_mode == bf_pkg::MODE_MIRROR) begin
          rr = mirror_pos(orow, dy, h);
          cc = mirror_pos(ocol, dx, w);
          px = line_mem[line_addr(rr, cc)];
        end else begin
          used = 0;
        end
        if (used) begin
          for (k = 0; k < 3; k++) begin
            cv = ctr[8*k +: 8];
            pv = px[8*k +: 8];
            diff = (cv > pv) ? cv - pv : pv - cv;
            wt = (sw * rg_weight[diff]) >> bf_pkg::WEIGHT_BITS;
            den[k] += wt;
            num[k] += wt * pv;
          end
        end
      end
    end
    for (k = 0; k < 3; k++) begin
      if (den[k] == 0) begin
        v = ctr[8*k +: 8];
      end else begin
        v = (num[k] + den[k] / 2) / den[k];
        if (v > 255) v = 255;
      end
      if (k == 0) res.red_out = v[7:0];
      else if (k == 1) res.green_out = v[7:0];
      else res.blue_out = v[7:0];
    end
    last = (orow == h - 1) && (ocol == w - 1);
    res.frame_end = last;
    if (last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return res;
  endfunction

  // Apply one accepted item; returns 1 when it yields a filtered pixel.
  function automatic bit filter_step(bf_pkg::in_t it, output bf_pkg::out_t res);
    int unsigned w, h, lag, in_lin, out_lin;
    res = '0;
    if (it.operation == bf_pkg::OP_LOAD_SP) begin
      if (it.table_index < bf_pkg::SPATIAL_ENTRIES) sp_weight[it.table_index] = it.weight_value;
      return 0;
    end
    if (it.operation == bf_pkg::OP_LOAD_RG) begin
      rg_weight[it.table_index] = it.weight_value;
      return 0;
    end
    if (frame_in_done) begin
      res = filter_pixel();
      return 1;
    end
    if (it.operation == bf_pkg::OP_DRAIN) return 0;
    w = geo_w();
    h = geo_h();
    line_mem[line_addr(in_row, in_col)] = {it.blue_in, it.green_in, it.red_in};
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) begin
        in_row = 0;
        frame_in_done = 1;
      end
    end
    if (frame_in_done) begin
      res = filter_pixel();
      return 1;
    end
    lag = geo_r() * w + geo_r();
    in_lin = in_row * w + in_col;
    out_lin = out_row * w + out_col;
    if (in_lin - out_lin > lag) begin
      res = filter_pixel();
      return 1;
    end
    return 0;
  endfunction

  // Offer one item until the block takes it, then predict its result.
  task automatic send_item(bf_pkg::in_t it);
    bf_pkg::out_t res;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
    if (filter_step(it, res)) pixel_q.push_back(res);
  endtask

  // Sender pause: wait for every expected pixel, then let the back end settle.
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      bf_pkg::CFG_WIDTH:  begin reg_w = 32'(val[10:0]); restart_frame(); end
      bf_pkg::CFG_HEIGHT: begin reg_h = 32'(val); restart_frame(); end
      bf_pkg::CFG_RADIUS: begin reg_r = 32'(val[1:0]); restart_frame(); end
      default:            reg_mode = 32'(val[1:0]);
    endcase
  endtask

  task automatic set_geometry(int w, int h, int r, int mode);
    wait_idle();
    write_cfg(bf_pkg::CFG_WIDTH, 13'(w));
    write_cfg(bf_pkg::CFG_HEIGHT, 13'(h));
    write_cfg(bf_pkg::CFG_RADIUS, 13'(r));
    write_cfg(bf_pkg::CFG_MODE, 13'(mode));
  endtask

  function automatic bf_pkg::in_t make_item(logic [1:0] op, logic [7:0] idx,
                                            logic [15:0] wv);
    bf_pkg::in_t it;
    it.operation = op;
    it.red_in = 8'($urandom);
    it.green_in = 8'($urandom);
    it.blue_in = 8'($urandom);
    it.table_index = idx;
    it.weight_value = wv;
    return it;
  endfunction

  function automatic bf_pkg::in_t rand_pixel();
    bf_pkg::in_t it;
    it = make_item(bf_pkg::OP_PIXEL, 8'($urandom), 16'($urandom));
    if ($urandom_range(9) == 0) it.red_in = $urandom_range(1) ? 8'hFF : 8'h00;
    if ($urandom_range(9) == 0) it.blue_in = $urandom_range(1) ? 8'hFF : 8'h00;
    return it;
  endfunction

  // Feed pixels with occasional noise, then drain until the frame is done.
  task automatic feed_frame(int npix, int noise_pct);
    int i;
    for (i = 0; i < npix; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0: send_item(make_item(bf_pkg::OP_DRAIN, 8'($urandom), 16'($urandom)));
          1: send_item(make_item(bf_pkg::OP_LOAD_RG, 8'($urandom), 16'($urandom)));
          default: send_item(make_item(bf_pkg::OP_LOAD_SP, 8'($urandom_range(63)),
                                       16'($urandom)));
        endcase
      end
      send_item(rand_pixel());
    end
    // A pixel while the frame is complete counts as a drain.
    while (frame_in_done) begin
      if ($urandom_range(3) == 0) send_item(rand_pixel());
      else send_item(make_item(bf_pkg::OP_DRAIN, 8'($urandom), 16'($urandom)));
    end
  endtask

  // Result side: check each transfer, then choose the next pop.
  initial begin
    bf_pkg::out_t exp_px;
    out_pop = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected pixel %h", out_data);
        end else begin
          exp_px = pixel_q.pop_front();
          if (out_data.red_out !== exp_px.red_out || out_data.green_out !== exp_px.green_out ||
              out_data.blue_out !== exp_px.blue_out ||
              out_data.frame_end !== exp_px.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Pixel mismatch: expected r%0d g%0d b%0d e%0d, got r%0d g%0d b%0d e%0d",
                       exp_px.red_out, exp_px.green_out, exp_px.blue_out, exp_px.frame_end,
                       out_data.red_out, out_data.green_out, out_data.blue_out,
                       out_data.frame_end);
          end
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (!rst_n) begin
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // Load both weight tables, including ignored out-of-range spatial loads.
  task automatic test_weight_load();
    int i;
    for (i = 0; i < bf_pkg::SPATIAL_ENTRIES; i++)
      send_item(make_item(bf_pkg::OP_LOAD_SP, 8'(i), 16'($urandom_range(1000, 65535))));
    for (i = 0; i < bf_pkg::RANGE_ENTRIES; i++)
      send_item(make_item(bf_pkg::OP_LOAD_RG, 8'(i), (i == 0) ? 16'hFFFF : 16'($urandom)));
    send_item(make_item(bf_pkg::OP_LOAD_SP, 8'hFF, 16'h0000));
    send_item(make_item(bf_pkg::OP_LOAD_SP, 8'd49, 16'h0000));
  endtask

  // Short directed frame: extreme samples, early drain, pixel after completion.
  task automatic test_directed();
    bf_pkg::in_t it;
    int i;
    set_geometry(3, 3, 1, bf_pkg::MODE_ZERO);
    send_item(make_item(bf_pkg::OP_DRAIN, 8'h00, 16'h0000));
    for (i = 0; i < 9; i++) begin
      it = make_item(bf_pkg::OP_PIXEL, 8'hAA, 16'h5555);
      it.red_in = (i % 2) ? 8'hFF : 8'h00;
      it.green_in = (i % 3) ? 8'h00 : 8'hFF;
      it.blue_in = 8'hFF - it.red_in;
      send_item(it);
    end
    send_item(make_item(bf_pkg::OP_PIXEL, 8'h55, 16'hAAAA));
    while (frame_in_done) send_item(make_item(bf_pkg::OP_DRAIN, 8'hFF, 16'hFFFF));
  endtask

  // Zero spatial weights in the radius-one window force the center sample.
  task automatic test_zero_denominator();
    int dy, dx;
    set_geometry(2, 2, 1, bf_pkg::MODE_ZERO);
    for (dy = 2; dy <= 4; dy++)
      for (dx = 2; dx <= 4; dx++)
        send_item(make_item(bf_pkg::OP_LOAD_SP, 8'(dy * bf_pkg::TAPS_SIDE + dx), 16'h0000));
    feed_frame(4, 0);
    for (dy = 2; dy <= 4; dy++)
      for (dx = 2; dx <= 4; dx++)
        send_item(make_item(bf_pkg::OP_LOAD_SP, 8'(dy * bf_pkg::TAPS_SIDE + dx), 16'hFFFF));
  endtask

  task automatic test_border_modes();
    int mode;
    for (mode = 0; mode < 4; mode++) begin
      set_geometry(5, 4, 2, mode);
      feed_frame(20, 0);
    end
  endtask

  // Clamped register values: a one-pixel frame from all-zero geometry, then
  // a part of a frame at the widest and tallest clamp, abandoned later.
  task automatic test_geometry_extremes();
    set_geometry(0, 0, 0, bf_pkg::MODE_MIRROR);
    feed_frame(1, 0);
    set_geometry(2047, 8191, 3, bf_pkg::MODE_MIRROR);
    feed_frame(24, 0);
  endtask

  // Long receiver hold-off while the sender keeps offering pixels.
  task automatic test_backpressure();
    set_geometry(8, 8, 1, bf_pkg::MODE_MIRROR);
    hold_req = 600;
    feed_frame(64, 0);
  endtask

  task automatic test_random();
    int ph, w, h;
    ph = 0;
    while (items_sent < 650 || ph < 4) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 57; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 57; end
        default: begin send_idle_pct = 22; pop_stall_pct = 22; end
      endcase
      w = ($urandom_range(9) < 8) ? $urandom_range(1, 10) : $urandom_range(11, 40);
      h = $urandom_range(1, 5);
      set_geometry(w, h, $urandom_range(3), $urandom_range(3));
      // Now and then a frame is abandoned part way by the next geometry write.
      if ($urandom_range(9) == 0) feed_frame($urandom_range(w * h), 5);
      else feed_frame(w * h, 5);
      ph++;
    end
    send_idle_pct = 0;
    pop_stall_pct = 0;
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = bf_pkg::CFG_WIDTH;
    cfg_data = '0;
    mismatches = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_req = 0;
    items_sent = 0;
    reg_w = 640;
    reg_h = 480;
    reg_r = 3;
    reg_mode = 2;
    restart_frame();
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (sp_weight[i]) sp_weight[i] = '0;
    foreach (rg_weight[i]) rg_weight[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_weight_load();
    test_directed();
    test_zero_denominator();
    test_border_modes();
    test_geometry_extremes();
    test_backpressure();
    test_random();

    wait_idle();
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
